>>> hdl/orsr_pkg.sv
// ----------------------------------------------------------------------------
// orsr_pkg - overwrite ring snapshot reader package
// Command codes, field widths and default sizes shared by the ring files.
// ----------------------------------------------------------------------------
package orsr_pkg;

    // Default ring depth and stored record width
    localparam int MAX_SLOTS_DEF    = 1024;
    localparam int RECORD_WIDTH_DEF = 64;

    // Fixed field widths on the ports
    localparam int REC_PORT_W = 64;   // record_in / record_out
    localparam int CNT_W      = 11;   // snapshot_count, iteration counters
    localparam int CFG_W      = 11;   // ring_capacity register
    localparam int CMD_W      = 2;

    // Packed word widths
    localparam int S_USER_W = CMD_W + 1;                       // cmd, clear_read
    localparam int M_DATA_W = ((REC_PORT_W + CNT_W + 7) / 8) * 8;
    localparam int M_USER_W = 1;                               // record_valid

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_BEGIN  = 2'd1,
        CMD_NEXT   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

endpackage

>>> hdl/orsr_ram.sv
// ----------------------------------------------------------------------------
// orsr_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module orsr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/overwrite_ring_snapshot_reader.sv
// Latency: a result word appears on m_ the cycle after its command word is taken.
// Throughput: one command word per cycle while s_tready is high; the ring memory has
//   one write and one registered read port, and no command needs more than one access.
// Stalls: s_tready drops while a result word waits on m_tready, and while cfg_valid is high.
// Reset (aresetn low, synchronous): pointers, full flag and iterator clear,
//   capacity returns to MAX_SLOTS. Record storage is not cleared; no sweep.
// ----------------------------------------------------------------------------
// overwrite_ring_snapshot_reader - overwriting record ring with snapshots
// Record ring that drops its oldest record when full, with a snapshot
// iterator (begin / next / end) that walks the records live at begin.
// ----------------------------------------------------------------------------
module overwrite_ring_snapshot_reader #(
    parameter int MAX_SLOTS    = orsr_pkg::MAX_SLOTS_DEF,
    parameter int RECORD_WIDTH = orsr_pkg::RECORD_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Capacity register write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [orsr_pkg::CFG_W-1:0]     cfg_wdata,    // ring_capacity

    // Command words
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [orsr_pkg::REC_PORT_W-1:0] s_tdata,     // [63:0] record_in
    input  logic [orsr_pkg::S_USER_W-1:0]  s_tuser,      // [1:0] cmd, [2] clear_read

    // Result words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [orsr_pkg::M_DATA_W-1:0]  m_tdata,      // [63:0] record_out,
                                                         // [74:64] snapshot_count, rest 0
    output logic [orsr_pkg::M_USER_W-1:0]  m_tuser       // [0] record_valid
);

    import orsr_pkg::*;

    localparam int PTR_W = $clog2(MAX_SLOTS);
    localparam int CAP_W = $clog2(MAX_SLOTS + 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [CAP_W-1:0] cap_reg,        cap_next;
    logic [PTR_W-1:0] wr_ptr_reg,     wr_ptr_next;
    logic [PTR_W-1:0] old_ptr_reg,    old_ptr_next;
    logic             full_reg,       full_next;
    logic [PTR_W-1:0] it_pos_reg,     it_pos_next;
    logic [PTR_W-1:0] it_end_reg,     it_end_next;
    logic [CNT_W-1:0] it_total_reg,   it_total_next;
    logic [CNT_W-1:0] it_done_reg,    it_done_next;

    // Result stage (record itself comes from the RAM read register)
    logic             res_valid_reg,  res_valid_next;
    logic             res_rec_vld_reg, res_rec_vld_next;
    logic [CNT_W-1:0] res_count_reg,  res_count_next;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic s_fire;
    logic cfg_fire;
    logic [31:0] cfg_ext;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    // result stage frees up when empty or being drained this cycle;
    // a capacity write takes the cycle, so no command word alongside it
    assign s_tready  = (~res_valid_reg | m_tready) & ~cfg_valid;
    assign s_fire    = s_tvalid & s_tready;
    assign cfg_ext   = 32'(cfg_wdata);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p,
                                                   input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] inc;
        inc = CAP_W'(p) + CAP_W'(1);
        return (inc >= cap) ? '0 : inc[PTR_W-1:0];
    endfunction

    cmd_t             cmd;
    logic             clr;
    logic [CAP_W-1:0] live;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic             rd_hit;

    assign cmd = cmd_t'(s_tuser[CMD_W-1:0]);
    assign clr = s_tuser[CMD_W];

    always_comb begin
        if (full_reg) begin
            live = cap_reg;
        end else if (wr_ptr_reg >= old_ptr_reg) begin
            live = CAP_W'(wr_ptr_reg) - CAP_W'(old_ptr_reg);
        end else begin
            live = cap_reg - CAP_W'(old_ptr_reg) + CAP_W'(wr_ptr_reg);
        end
    end

    assign wr_ptr_inc = next_slot(wr_ptr_reg, cap_reg);
    assign rd_hit     = (it_done_reg < it_total_reg);

    // ------------------------------------------------------------------
    // Command decode / next state
    // ------------------------------------------------------------------
    always_comb begin
        cap_next         = cap_reg;
        wr_ptr_next      = wr_ptr_reg;
        old_ptr_next     = old_ptr_reg;
        full_next        = full_reg;
        it_pos_next      = it_pos_reg;
        it_end_next      = it_end_reg;
        it_total_next    = it_total_reg;
        it_done_next     = it_done_reg;
        res_valid_next   = res_valid_reg & ~m_tready;
        res_rec_vld_next = res_rec_vld_reg;
        res_count_next   = res_count_reg;

        if (cfg_fire) begin
            // clamp to 1..MAX_SLOTS and empty the ring
            if (cfg_ext == 32'd0) begin
                cap_next = CAP_W'(1);
            end else if (cfg_ext > 32'(MAX_SLOTS)) begin
                cap_next = CAP_W'(MAX_SLOTS);
            end else begin
                cap_next = CAP_W'(cfg_ext);
            end
            wr_ptr_next   = '0;
            old_ptr_next  = '0;
            full_next     = 1'b0;
            it_pos_next   = '0;
            it_end_next   = '0;
            it_total_next = '0;
            it_done_next  = '0;
        end else if (s_fire) begin
            res_valid_next   = 1'b1;
            res_rec_vld_next = 1'b0;
            res_count_next   = '0;
            case (cmd)
                CMD_APPEND: begin
                    wr_ptr_next = wr_ptr_inc;
                    if (full_reg) begin
                        old_ptr_next = wr_ptr_inc;   // oldest overwritten
                    end else if (wr_ptr_inc == old_ptr_reg) begin
                        full_next = 1'b1;
                    end
                end
                CMD_BEGIN: begin
                    it_total_next  = CNT_W'(live);
                    it_pos_next    = old_ptr_reg;
                    it_end_next    = wr_ptr_reg;
                    it_done_next   = '0;
                    res_count_next = CNT_W'(live);
                end
                CMD_NEXT: begin
                    if (rd_hit) begin
                        res_rec_vld_next = 1'b1;
                        it_pos_next      = next_slot(it_pos_reg, cap_reg);
                        it_done_next     = it_done_reg + CNT_W'(1);
                    end
                end
                CMD_END: begin
                    // keep records appended since begin
                    if (clr && (it_total_reg != '0)) begin
                        old_ptr_next = it_end_reg;
                        full_next    = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg         <= CAP_W'(MAX_SLOTS);
            wr_ptr_reg      <= '0;
            old_ptr_reg     <= '0;
            full_reg        <= 1'b0;
            it_pos_reg      <= '0;
            it_end_reg      <= '0;
            it_total_reg    <= '0;
            it_done_reg     <= '0;
            res_valid_reg   <= 1'b0;
            res_rec_vld_reg <= 1'b0;
            res_count_reg   <= '0;
        end else begin
            cap_reg         <= cap_next;
            wr_ptr_reg      <= wr_ptr_next;
            old_ptr_reg     <= old_ptr_next;
            full_reg        <= full_next;
            it_pos_reg      <= it_pos_next;
            it_end_reg      <= it_end_next;
            it_total_reg    <= it_total_next;
            it_done_reg     <= it_done_next;
            res_valid_reg   <= res_valid_next;
            res_rec_vld_reg <= res_rec_vld_next;
            res_count_reg   <= res_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Record store: append writes at the head, read next fetches at the
    // iterator position. Read data register only loads on a read, so it
    // holds while the result word is stalled.
    // ------------------------------------------------------------------
    logic                    ram_we;
    logic                    ram_re;
    logic [RECORD_WIDTH-1:0] ram_rdata;

    assign ram_we = s_fire & ~cfg_fire & (cmd == CMD_APPEND);
    assign ram_re = s_fire & ~cfg_fire & (cmd == CMD_NEXT) & rd_hit;

    orsr_ram #(
        .WIDTH (RECORD_WIDTH),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_ptr_reg),
        .wr_data (s_tdata[RECORD_WIDTH-1:0]),
        .rd_en   (ram_re),
        .rd_addr (it_pos_reg),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Result word
    // ------------------------------------------------------------------
    logic [REC_PORT_W-1:0] rec_out;

    assign rec_out  = res_rec_vld_reg ? REC_PORT_W'(ram_rdata) : '0;
    assign m_tvalid = res_valid_reg;
    assign m_tdata  = M_DATA_W'({res_count_reg, rec_out});
    assign m_tuser  = res_rec_vld_reg;

endmodule
